/* hdl/prc_pkg.sv */
// prc_pkg: types, codes and constants of the packet rule classifier
// no dependencies
package prc_pkg;

   localparam int RULE_SLOTS = 16;
   localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] FLAGS_SYN_ONLY = 8'h02;

   typedef enum logic [2:0] {
      FUNC_CLASSIFY = 3'd0,
      FUNC_ADD      = 3'd1,
      FUNC_DELETE   = 3'd2,
      FUNC_CLEAR    = 3'd3,
      FUNC_ZERO     = 3'd4
   } func_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [1:0] REG_RULE_EN = 2'd0;
   localparam logic [1:0] REG_SESSION_EN = 2'd1;
   localparam logic [1:0] REG_SYN_DROP_EN = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] src_mask;
      logic [31:0] dst_addr;
      logic [31:0] dst_mask;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  tcp_flags;
      logic [15:0] packet_length;
      logic [15:0] rule_id;
   } req_type;

   typedef struct packed {
      logic        drop;
      logic [1:0]  status;
      logic [31:0] byte_total;
   } rsp_type;

   // front to back: what the back has to do with the total, plus drop and status
   typedef struct packed {
      logic        add_len;
      logic        zero;
      logic        drop;
      logic [1:0]  status;
      logic [15:0] packet_length;
   } job_type;

   typedef struct packed {
      logic rule_en;
      logic session_en;
      logic syn_drop_en;
   } cfg_type;

endpackage

/* hdl/prc_stream_if.sv */
// prc_stream_if: valid/ready channel carrying one payload word
// depends on prc_pkg
interface prc_req_if;
   logic             valid;
   logic             ready;
   prc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface prc_rsp_if;
   logic             valid;
   logic             ready;
   prc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/packet_rule_classifier.sv */
// packet_rule_classifier: top level, front, queue, back and register port
// depends on prc_pkg, prc_stream_if, prc_front, prc_queue, prc_back
//
// channel  direction  handshake         payload
// req      in         valid/ready       func, header, rule fields
// rsp      out        valid/ready       drop, status, byte_total
// csr      in         apb write/read    three enable bits
//
// an item is registered into the front's stage, then matched against
// all slots; the front takes the next item when its stage empties
// results leave in the cycle after the back takes the job, through an output register
// synchronous active high reset clears the rule valid bits, total and enables
// a stalled rsp fills the queue, after which the front holds its item
module packet_rule_classifier (
   input  logic        clock,
   input  logic        reset,
   prc_req_if.sink     req,
   prc_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   prc_pkg::cfg_type cfg_ff, cfg_in;
   logic             fj_valid, fj_ready, bj_valid, bj_ready;
   prc_pkg::job_type fj, bj;
   logic [1:0]       reg_idx;
   logic             wr;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[3:2];
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0;

   always_comb begin
      cfg_in = cfg_ff;
      csr_prdata = '0;
      case (reg_idx)
         prc_pkg::REG_RULE_EN: begin
            csr_prdata[0] = cfg_ff.rule_en;
            if (wr) cfg_in.rule_en = csr_pwdata[0];
         end
         prc_pkg::REG_SESSION_EN: begin
            csr_prdata[0] = cfg_ff.session_en;
            if (wr) cfg_in.session_en = csr_pwdata[0];
         end
         prc_pkg::REG_SYN_DROP_EN: begin
            csr_prdata[0] = cfg_ff.syn_drop_en;
            if (wr) cfg_in.syn_drop_en = csr_pwdata[0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   prc_front u_front (
      .clock(clock), .reset(reset), .req(req), .cfg(cfg_ff),
      .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
   );

   prc_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
   );

   prc_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj), .rsp(rsp)
   );

endmodule

/* hdl/prc_front.sv */
// prc_front: accepts items, holds the rule table, matches and edits rules
// depends on prc_pkg
module prc_front (
   input  logic              clock,
   input  logic              reset,
   prc_req_if.sink           req,
   input  prc_pkg::cfg_type  cfg,
   output logic              job_valid,
   output prc_pkg::job_type  job,
   input  logic              job_ready
);

   localparam int N = prc_pkg::RULE_SLOTS;

   logic [N-1:0]  valid_ff, valid_in;
   logic [7:0]    proto_ff [N];
   logic [31:0]   sa_ff [N];
   logic [31:0]   sm_ff [N];
   logic [31:0]   da_ff [N];
   logic [31:0]   dm_ff [N];
   logic [31:0]   ports_ff [N];
   logic [15:0]   ident_ff [N];

   // stage: item held while it is matched and until its job is taken
   logic             busy_ff, busy_in;
   prc_pkg::req_type item_ff, item_in;

   logic [N-1:0] hit_vec, free_vec, id_vec;
   logic [N-1:0] free_sel, id_sel;
   logic         l4_ok, syn_hit, fire;
   logic [15:0]  r_sp, r_dp;

   always_comb begin
      l4_ok = (item_ff.protocol == prc_pkg::PROTO_TCP) ||
              (item_ff.protocol == prc_pkg::PROTO_UDP);
      for (int k = 0; k < N; k++) begin
         r_sp = ports_ff[k][31:16];
         r_dp = ports_ff[k][15:0];
         hit_vec[k] = valid_ff[k] && l4_ok &&
            (proto_ff[k] == 8'd0 || proto_ff[k] == item_ff.protocol) &&
            (sa_ff[k] == 32'd0 || (item_ff.src_addr & sm_ff[k]) == sa_ff[k]) &&
            (da_ff[k] == 32'd0 || (item_ff.dst_addr & dm_ff[k]) == da_ff[k]) &&
            (r_sp == 16'd0 || r_sp == item_ff.src_port) &&
            (r_dp == 16'd0 || r_dp == item_ff.dst_port);
         free_vec[k] = !valid_ff[k];
         id_vec[k] = valid_ff[k] && (ident_ff[k] == item_ff.rule_id);
      end
      // lowest set bit
      free_sel = free_vec & (~free_vec + N'(1));
      id_sel = id_vec & (~id_vec + N'(1));
      syn_hit = cfg.session_en && cfg.syn_drop_en &&
                item_ff.protocol == prc_pkg::PROTO_TCP &&
                item_ff.tcp_flags == prc_pkg::FLAGS_SYN_ONLY;
   end

   assign job_valid = busy_ff;
   assign fire = busy_ff && job_ready;
   assign req.ready = !busy_ff;

   always_comb begin
      job = '0;
      job.packet_length = item_ff.packet_length;
      job.status = prc_pkg::ST_OK;
      valid_in = valid_ff;
      case (item_ff.func)
         prc_pkg::FUNC_CLASSIFY: begin
            job.drop = (cfg.rule_en && (|hit_vec)) || syn_hit;
            job.add_len = !job.drop;
         end
         prc_pkg::FUNC_ADD: begin
            if (|free_vec) valid_in = valid_ff | free_sel;
            else job.status = prc_pkg::ST_FULL;
         end
         prc_pkg::FUNC_DELETE: begin
            if (|id_vec) valid_in = valid_ff & ~id_sel;
            else job.status = prc_pkg::ST_NOT_FOUND;
         end
         prc_pkg::FUNC_CLEAR: valid_in = '0;
         prc_pkg::FUNC_ZERO:  job.zero = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      item_in = item_ff;
      if (fire) busy_in = 1'b0;
      if (req.valid && !busy_ff) begin
         busy_in = 1'b1;
         item_in = req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         if (fire) valid_ff <= valid_in;
      end
      item_ff <= item_in;
      for (int k = 0; k < N; k++) begin
         if (fire && item_ff.func == prc_pkg::FUNC_ADD && free_sel[k]) begin
            proto_ff[k] <= item_ff.protocol;
            sa_ff[k] <= item_ff.src_addr;
            sm_ff[k] <= item_ff.src_mask;
            da_ff[k] <= item_ff.dst_addr;
            dm_ff[k] <= item_ff.dst_mask;
            ports_ff[k] <= {item_ff.src_port, item_ff.dst_port};
            ident_ff[k] <= item_ff.rule_id;
         end
      end
   end

   a_one_free: assert property (@(posedge clock) disable iff (reset)
      $onehot0(free_sel)) else $error("free select not onehot");
   a_one_id: assert property (@(posedge clock) disable iff (reset)
      $onehot0(id_sel)) else $error("delete select not onehot");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      fire && item_ff.func == prc_pkg::FUNC_CLEAR |=> valid_ff == '0)
      else $error("clear left rules");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !job_ready |=> busy_ff && $stable(item_ff))
      else $error("stalled item changed");

endmodule

/* hdl/prc_queue.sv */
// prc_queue: short fifo between front and back
// depends on prc_pkg
module prc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  prc_pkg::job_type  in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output prc_pkg::job_type  out_job
);

   localparam int D = prc_pkg::QUEUE_DEPTH;
   localparam int AW = $clog2(D);

   prc_pkg::job_type mem_ff [D];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready = cnt_ff != (AW+1)'(D);
   assign out_valid = cnt_ff != '0;
   assign out_job = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wp_in = push ? ((wp_ff == AW'(D-1)) ? '0 : wp_ff + AW'(1)) : wp_ff;
      rp_in = pop ? ((rp_ff == AW'(D-1)) ? '0 : rp_ff + AW'(1)) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(D)) else $error("queue overflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + (AW+1)'(1))
      else $error("queue count slip");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> wp_ff == rp_ff) else $error("empty queue pointers differ");

endmodule

/* hdl/prc_back.sv */
// prc_back: keeps the forwarded byte total and drives the result register
// depends on prc_pkg
module prc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  prc_pkg::job_type  job,
   prc_rsp_if.source         rsp
);

   logic [31:0]      total_ff, total_in;
   logic             out_valid_ff, out_valid_in;
   prc_pkg::rsp_type out_ff, out_in;
   logic             take;

   assign job_ready = !out_valid_ff || rsp.ready;
   assign take = job_valid && job_ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   always_comb begin
      total_in = total_ff;
      if (job.zero) total_in = '0;
      else if (job.add_len) total_in = total_ff + {16'd0, job.packet_length};
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (take) begin
         out_valid_in = 1'b1;
         out_in.drop = job.drop;
         out_in.status = job.status;
         out_in.byte_total = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) total_ff <= total_in;
      end
      out_ff <= out_in;
   end

   a_total: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp.data.byte_total == total_ff) else $error("total mismatch");
   a_drop_ok: assert property (@(posedge clock) disable iff (reset)
      take && job.drop |=> $stable(total_ff)) else $error("dropped packet counted");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.data.status != 2'd3) else $error("bad status");

endmodule
